[sv/dqc_pkg.sv]
// Shared types and codes for the double-ended queue core.
// Used by dqc_cell, dqc_chain and double_ended_queue_core; depends on nothing.
package dqc_pkg;

  // Operation requested by one input transaction.
  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  // Completion code returned with every result.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What one storage cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_FROM_LO = 2'd1,
    CELL_FROM_HI = 2'd2,
    CELL_LOAD    = 2'd3
  } cell_op_t;

  // What a whole chain of cells does at the next edge.
  typedef enum logic [1:0] {
    MODE_HOLD       = 2'd0,
    MODE_SHIFT_UP   = 2'd1,
    MODE_SHIFT_DOWN = 2'd2,
    MODE_WRITE_AT   = 2'd3
  } chain_mode_t;

endpackage

[sv/dqc_cell.sv]
// One storage cell of a deque chain: holds a word, or takes it from a neighbor or the load bus.
// Depends on dqc_pkg.
module dqc_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  dqc_pkg::cell_op_t     op,
  input  logic [DATA_WIDTH-1:0] from_lo,
  input  logic [DATA_WIDTH-1:0] from_hi,
  input  logic [DATA_WIDTH-1:0] load_word,
  output logic [DATA_WIDTH-1:0] word
);
  import dqc_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_FROM_LO: word <= from_lo;
      CELL_FROM_HI: word <= from_hi;
      CELL_LOAD:    word <= load_word;
      CELL_HOLD:    word <= word;
      default:      word <= word;
    endcase
  end

endmodule

[sv/dqc_chain.sv]
// A row of dqc_cell instances that shifts up, shifts down or writes one addressed cell.
// Depends on dqc_pkg and dqc_cell.
module dqc_chain #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter bit READ_HI    = 1'b0
) (
  input  logic                       clk,
  input  dqc_pkg::chain_mode_t       mode,
  input  logic [$clog2(DEPTH)-1:0]   pos,
  input  logic [DATA_WIDTH-1:0]      load_word,
  output logic [DATA_WIDTH-1:0]      word_end
);
  import dqc_pkg::*;

  localparam int IdxW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo_word;
    logic [DATA_WIDTH-1:0] hi_word;
    cell_op_t              cell_op;

    if (i == 0) begin : g_lo_edge
      assign lo_word = load_word;
    end else begin : g_lo_link
      assign lo_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_word = load_word;
    end else begin : g_hi_link
      assign hi_word = words[i+1];
    end

    // The end cell of a shift takes the load bus; the rest take their neighbor.
    always_comb begin
      case (mode)
        MODE_SHIFT_UP:   cell_op = (i == 0) ? CELL_LOAD : CELL_FROM_LO;
        MODE_SHIFT_DOWN: cell_op = (i == DEPTH - 1) ? CELL_LOAD : CELL_FROM_HI;
        MODE_WRITE_AT:   cell_op = (pos == IdxW'(i)) ? CELL_LOAD : CELL_HOLD;
        default:         cell_op = CELL_HOLD;
      endcase
    end

    dqc_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .from_lo   (lo_word),
      .from_hi   (hi_word),
      .load_word (load_word),
      .word      (words[i])
    );
  end

  // Only one end of the row is ever read by the user of a chain.
  assign word_end = READ_HI ? words[DEPTH-1] : words[0];

endmodule

[sv/double_ended_queue_core.sv]
// A result appears in the output register in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the output side takes results; both ends of
//   the queue sit at fixed cells of two shift chains, so no operation waits on another.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result;
//   the stored words are not cleared, since no pop can reach a word that was never pushed.
// Top level of the double-ended queue; depends on dqc_pkg and dqc_chain.
module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [DATA_WIDTH-1:0]        value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DATA_WIDTH-1:0]        value_out,
  output logic [1:0]                   status,
  output logic                         is_empty,
  output logic [$clog2(DEPTH+1)-1:0]   fill_count
);
  import dqc_pkg::*;

  localparam int IdxW   = $clog2(DEPTH);
  localparam int CountW = $clog2(DEPTH + 1);

  // The queue is kept twice. The front chain holds the front entry in its cell zero and
  // the rest in order above it. The back chain holds the back entry in its top cell and
  // the rest in order below it. A pop at either end thus always reads a fixed cell, and
  // a push at the far end of a chain is a broadcast write to the cell that the count
  // selects, which each cell decodes for itself.
  logic [CountW-1:0]     count;
  logic [CountW-1:0]     count_next;
  chain_mode_t           mode_front;
  chain_mode_t           mode_back;
  logic [IdxW-1:0]       pos_front;
  logic [IdxW-1:0]       pos_back;
  logic [DATA_WIDTH-1:0] front_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] word_next;
  status_t               status_next;
  func_t                 op;
  logic                  accept;
  logic                  queue_full;
  logic                  queue_void;

  assign op         = func_t'(func);
  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign queue_full = (count == CountW'(DEPTH));
  assign queue_void = (count == '0);

  // A push at the back lands just past the last entry of the front chain; a push at the
  // front lands just below the first entry of the back chain. Neither is used when full.
  assign pos_front = count[IdxW-1:0];
  assign pos_back  = IdxW'(DEPTH - 1) - count[IdxW-1:0];

  always_comb begin
    mode_front  = MODE_HOLD;
    mode_back   = MODE_HOLD;
    count_next  = count;
    word_next   = '0;
    status_next = ST_DONE;
    if (accept) begin
      case (op)
        FUNC_PUSH_BACK: begin
          if (queue_full) begin
            status_next = ST_FULL;
          end else begin
            mode_front = MODE_WRITE_AT;
            mode_back  = MODE_SHIFT_DOWN;
            count_next = count + CountW'(1);
          end
        end
        FUNC_PUSH_FRONT: begin
          if (queue_full) begin
            status_next = ST_FULL;
          end else begin
            mode_front = MODE_SHIFT_UP;
            mode_back  = MODE_WRITE_AT;
            count_next = count + CountW'(1);
          end
        end
        FUNC_POP_FRONT: begin
          if (queue_void) begin
            status_next = ST_EMPTY;
          end else begin
            // The back chain keeps its words; its lowest valid cell simply drops out of
            // the count.
            word_next  = front_word;
            mode_front = MODE_SHIFT_DOWN;
            count_next = count - CountW'(1);
          end
        end
        FUNC_POP_BACK: begin
          if (queue_void) begin
            status_next = ST_EMPTY;
          end else begin
            word_next  = back_word;
            mode_back  = MODE_SHIFT_UP;
            count_next = count - CountW'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  dqc_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .READ_HI    (1'b0)
  ) u_front_chain (
    .clk       (clk),
    .mode      (mode_front),
    .pos       (pos_front),
    .load_word (value),
    .word_end  (front_word)
  );

  dqc_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .READ_HI    (1'b1)
  ) u_back_chain (
    .clk       (clk),
    .mode      (mode_back),
    .pos       (pos_back),
    .load_word (value),
    .word_end  (back_word)
  );

  // Control state: the entry count and the output register's valid flag. A new
  // transaction may be accepted in the same cycle that the held result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; it only changes when a transaction is accepted, so a stalled
  // result holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_out  <= word_next;
      status     <= status_next;
      is_empty   <= (count_next == '0);
      fill_count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CountW'(1) ||
                     count + CountW'(1) == $past(count)))
    else $error("entry count moved by more than one entry");

  a_count_idle : assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("entry count changed without a transaction");

  a_refused_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> fill_count == CountW'(DEPTH) && value_out == '0)
    else $error("refused push reported on a queue that is not full");

  a_refused_empty : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> is_empty && fill_count == '0 && value_out == '0)
    else $error("refused pop reported on a queue that is not empty");
`endif

endmodule

[sim/dqc_result_checker.sv]
// Result checker for the double-ended queue core: predicts every result and compares it.
// Watches both channels of double_ended_queue_core; depends on dqc_pkg.
module dqc_result_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DATA_WIDTH-1:0] value_out,
  input  logic [1:0]            status,
  input  logic                  is_empty,
  input  logic [CW-1:0]         fill_count,
  output int                    fail_count,
  output int                    pending,
  output int                    ops_seen,
  output int                    results_seen,
  output int                    full_refusals,
  output int                    empty_refusals
);
  timeunit 1ns;
  timeprecision 1ps;
  import dqc_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] word;
    status_t               st;
    logic                  empty;
    logic [CW-1:0]         count;
  } deque_result_t;

  // Shadow copy of the queue contents.
  logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
  int                    shadow_head;
  int                    shadow_held;
  deque_result_t         expected_results [$];

  task automatic report(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one operation to the shadow queue and returns the result it must give.
  function automatic deque_result_t apply_deque_op(input func_t f,
                                                   input logic [DATA_WIDTH-1:0] v);
    deque_result_t r;
    r.word = '0;
    r.st   = ST_DONE;
    case (f)
      FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
        if (shadow_held == DEPTH) begin
          r.st = ST_FULL;
        end else if (f == FUNC_PUSH_BACK) begin
          shadow_ring[(shadow_head + shadow_held) % DEPTH] = v;
          shadow_held++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = v;
          shadow_held++;
        end
      end
      default: begin
        if (shadow_held == 0) begin
          r.st = ST_EMPTY;
        end else if (f == FUNC_POP_FRONT) begin
          r.word      = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_held--;
        end else begin
          r.word = shadow_ring[(shadow_head + shadow_held - 1) % DEPTH];
          shadow_held--;
        end
      end
    endcase
    r.empty = (shadow_held == 0);
    r.count = shadow_held[CW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_head    = 0;
      shadow_held    = 0;
      fail_count     = 0;
      ops_seen       = 0;
      results_seen   = 0;
      full_refusals  = 0;
      empty_refusals = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_deque_op(func_t'(func), value));
        ops_seen++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result: value_out %h status %0d count %0d",
                           value_out, status, fill_count));
        end else begin
          want = expected_results.pop_front();
          if (want.st == ST_FULL)  full_refusals++;
          if (want.st == ST_EMPTY) empty_refusals++;
          if (value_out !== want.word)
            report($sformatf("result %0d value_out %h, expected %h",
                             results_seen, value_out, want.word));
          if (status !== want.st)
            report($sformatf("result %0d status %0d, expected %s",
                             results_seen, status, want.st.name()));
          if (is_empty !== want.empty)
            report($sformatf("result %0d is_empty %b, expected %b",
                             results_seen, is_empty, want.empty));
          if (fill_count !== want.count)
            report($sformatf("result %0d fill_count %0d, expected %0d",
                             results_seen, fill_count, want.count));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[sim/tb_double_ended_queue_core.sv]
// Testbench top for double_ended_queue_core: drives operations and gives the verdict.
// Depends on dqc_pkg, double_ended_queue_core and dqc_result_checker.
module tb_double_ended_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dqc_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CW         = $clog2(DEPTH + 1);

  // Random part of the run, and the calm stretch at its end with no idling at all.
  localparam int RANDOM_OPS   = 1775;
  localparam int CALM_TAIL    = 200;
  // The run is declared hung after this many cycles without any accepted transaction.
  // The longest legitimate quiet stretch is an input gap plus an output stall burst,
  // far below this limit.
  localparam int QUIET_LIMIT  = 2000;
  // The result register sits behind the input; wait beyond the last pending result.
  localparam int DRAIN_CYCLES = 4;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [1:0]            func       = FUNC_PUSH_BACK;
  logic [DATA_WIDTH-1:0] value      = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [DATA_WIDTH-1:0] value_out;
  logic [1:0]            status;
  logic                  is_empty;
  logic [CW-1:0]         fill_count;

  int fail_count;
  int pending;
  int ops_seen;
  int results_seen;
  int full_refusals;
  int empty_refusals;

  // When clear, neither side inserts idle cycles. The stimulus process toggles it in
  // stretches so that some of the run goes at full rate.
  bit idle_on    = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .is_empty   (is_empty),
    .fill_count (fill_count)
  );

  dqc_result_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value_out      (value_out),
    .status         (status),
    .is_empty       (is_empty),
    .fill_count     (fill_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .ops_seen       (ops_seen),
    .results_seen   (results_seen),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output side: stall in random bursts. A burst starts with out_stall
  // raised and stall_left holding the number of further stalled cycles. Every burst
  // ends with out_stall lowered before another burst can start.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any cycle that moves a transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAIL double_ended_queue_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one operation and returns at the edge where it is accepted. The valid
  // stays high across back-to-back transactions; it only drops when a gap is
  // inserted, so it is never lowered and raised in the same time step.
  task automatic send_op(input func_t f, input logic [DATA_WIDTH-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    func_t                 f;
    logic [DATA_WIDTH-1:0] word;
    int                    tide_left;
    int                    push_pct;

    tide_left = 0;
    push_pct  = 50;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. Pops on the empty queue from both ends must be refused.
    send_op(FUNC_POP_FRONT, 32'hDEAD_BEEF);
    send_op(FUNC_POP_BACK, 32'h1234_5678);
    // Extreme words at each end, then take them back out from the same ends.
    send_op(FUNC_PUSH_BACK, '1);
    send_op(FUNC_PUSH_FRONT, '0);
    send_op(FUNC_POP_BACK, '0);
    send_op(FUNC_POP_FRONT, '1);
    // Fill the queue from both ends so the ring pointer wraps in both directions.
    for (int i = 0; i < DEPTH; i++) begin
      send_op(i[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
              (32'h1 << (2 * i)) ^ 32'hA5A5_0000);
    end
    // Pushes at either end of a full queue must be refused and change nothing.
    send_op(FUNC_PUSH_BACK, 32'h5A5A_5A5A);
    send_op(FUNC_PUSH_FRONT, 32'hC3C3_C3C3);
    send_op(FUNC_POP_BACK, '0);

    // Random part. The mix of pushes and pops drifts in tides so that the queue
    // swings between full and empty many times rather than hovering in the middle.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n >= RANDOM_OPS - CALM_TAIL) begin
        idle_on = 1'b0;
      end else if (n % 150 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end

      if (tide_left == 0) begin
        tide_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      tide_left--;

      if ($urandom_range(0, 99) < push_pct) begin
        f = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else begin
        f = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      end

      // Mostly full random words, with zeros, all ones and single-bit patterns mixed in.
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        2:       word = 32'h1 << $urandom_range(0, 31);
        3:       word = ~(32'h1 << $urandom_range(0, 31));
        default: word = $urandom();
      endcase

      send_op(f, word);
    end
    in_valid <= 1'b0;

    // Let the checker see the last accepted transaction before reading its count.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operations and checked %0d results,", ops_seen, results_seen);
    $display("including %0d pushes refused when full and %0d pops refused when empty.",
             full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("PASS double_ended_queue_core");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("FAIL double_ended_queue_core");
    end
    $finish;
  end

endmodule
